FILE: src/sps_pkg.sv
// ---------------------------------------------------------------------------
// sps_pkg
// Shared types, parse stage codes and helpers for the SPS header parser.
// ---------------------------------------------------------------------------
package sps_pkg;

    localparam int CodeWidthDefault = 32;
    localparam int FifoDepth        = 4;

    typedef enum logic [33:0] {
        ST_HDR     = 34'h000000001,
        ST_PROFILE = 34'h000000002,
        ST_CONSTR  = 34'h000000004,
        ST_LEVEL   = 34'h000000008,
        ST_SPSID   = 34'h000000010,
        ST_CHROMA  = 34'h000000020,
        ST_SEP     = 34'h000000040,
        ST_LDEPTH  = 34'h000000080,
        ST_CDEPTH  = 34'h000000100,
        ST_BYPASS  = 34'h000000200,
        ST_SMFLAG  = 34'h000000400,
        ST_LFLAG   = 34'h000000800,
        ST_LDELTA  = 34'h000001000,
        ST_LOG2FN  = 34'h000002000,
        ST_POCTYPE = 34'h000004000,
        ST_LOG2POC = 34'h000008000,
        ST_DPOAZ   = 34'h000010000,
        ST_OFFNR   = 34'h000020000,
        ST_OFFTB   = 34'h000040000,
        ST_NREF    = 34'h000080000,
        ST_OFFREF  = 34'h000100000,
        ST_MAXREF  = 34'h000200000,
        ST_GAPS    = 34'h000400000,
        ST_WIDTH   = 34'h000800000,
        ST_HEIGHT  = 34'h001000000,
        ST_FMO     = 34'h002000000,
        ST_MBAFF   = 34'h004000000,
        ST_D8      = 34'h008000000,
        ST_CROPF   = 34'h010000000,
        ST_CL      = 34'h020000000,
        ST_CR      = 34'h040000000,
        ST_CT      = 34'h080000000,
        ST_CB      = 34'h100000000,
        ST_DONE    = 34'h200000000
    } t_stage;

    // byte handed from the front end to the bit engine
    typedef struct packed {
        logic [7:0] data;
        logic       drop;
        logic       last;
    } t_byte_item;

    typedef struct packed {
        logic        valid_res;
        logic [7:0]  profile;
        logic [7:0]  level;
        logic [1:0]  chroma_format;
        logic [7:0]  luma_depth;
        logic [7:0]  chroma_depth;
        logic [15:0] pic_width;
        logic [15:0] pic_height;
        logic        frame_only;
    } t_result;

    // fixed read length per stage, 0 = Exp-Golomb
    function automatic logic [3:0] stage_bits(input t_stage s);
        case (s)
            ST_HDR, ST_PROFILE, ST_CONSTR, ST_LEVEL: stage_bits = 4'd8;
            ST_SEP, ST_BYPASS, ST_SMFLAG, ST_LFLAG, ST_DPOAZ, ST_GAPS,
            ST_FMO, ST_MBAFF, ST_D8, ST_CROPF:       stage_bits = 4'd1;
            default:                                 stage_bits = 4'd0;
        endcase
    endfunction

    function automatic logic high_profile(input logic [7:0] p);
        high_profile = (p == 8'd100) || (p == 8'd110) || (p == 8'd122) ||
                       (p == 8'd244) || (p == 8'd44)  || (p == 8'd83)  ||
                       (p == 8'd86)  || (p == 8'd118) || (p == 8'd128) ||
                       (p == 8'd138) || (p == 8'd139) || (p == 8'd134) ||
                       (p == 8'd135);
    endfunction

endpackage

FILE: src/sps_front.sv
// ---------------------------------------------------------------------------
// sps_front
// Accepts raw bytes and flags emulation-prevention bytes.
// ---------------------------------------------------------------------------
module sps_front
    import sps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data,
    input  logic       i_last,
    output logic       o_ready,
    output logic       o_push,
    output t_byte_item o_item,
    input  logic       i_full
);
    logic [1:0] r_zero_run;
    logic [1:0] n_zero_run;
    logic       w_drop;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign w_drop  = (r_zero_run == 2'd2) && (i_data == 8'h03);
    assign o_item  = '{data: i_data, drop: w_drop, last: i_last};

    always_comb begin
        n_zero_run = r_zero_run;
        if (o_push) begin
            if (w_drop || i_last) begin
                n_zero_run = 2'd0;
            end else if (i_data == 8'h00) begin
                n_zero_run = (r_zero_run == 2'd2) ? 2'd2 : r_zero_run + 2'd1;
            end else begin
                n_zero_run = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run <= 2'd0;
        end else begin
            r_zero_run <= n_zero_run;
        end
    end
endmodule

FILE: src/sps_fifo.sv
// ---------------------------------------------------------------------------
// sps_fifo
// Short queue between front end and bit engine.
// ---------------------------------------------------------------------------
module sps_fifo
    import sps_pkg::*;
#(
    parameter int DEPTH = FifoDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_byte_item i_item,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_empty,
    output t_byte_item o_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_byte_item        r_mem [DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

FILE: src/sps_engine.sv
// ---------------------------------------------------------------------------
// sps_engine
// Bit-serial SPS syntax engine, one bit per cycle unless stalled, with a result register.
// ---------------------------------------------------------------------------
module sps_engine
    import sps_pkg::*;
#(
    parameter int CODE_WIDTH = CodeWidthDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_byte_item i_item,
    output logic       o_pop,
    output logic       o_valid,
    output t_result    o_res,
    input  logic       i_ready
);
    localparam int LZW = $clog2(CODE_WIDTH + 1);

    t_stage           r_stage, n_stage;
    logic [2:0]       r_bit;
    logic [LZW-1:0]   r_lz, n_lz;
    logic [CODE_WIDTH-1:0] r_code, n_code;
    logic [LZW-1:0]   r_left, n_left;
    logic [3:0]       r_lidx, n_lidx;
    logic [6:0]       r_lent, n_lent;
    logic [7:0]       r_prev, n_prev;
    logic [31:0]      r_refrem, n_refrem;
    logic [31:0]      r_sz [6];
    logic [31:0]      n_sz [6];
    logic [7:0]       r_hf [6];
    logic [7:0]       n_hf [6];
    logic             r_err, n_err;
    // finishing pipeline for the size arithmetic
    logic             r_fin;
    logic             r_fin_ok;
    logic [35:0]      r_wpos, r_hpos, r_wneg, r_hneg;
    logic             r_ovalid;
    t_result          r_res;

    logic             w_busy_out, w_take, w_bit, w_done, w_endbyte;
    logic [31:0]      w_v, w_delta;
    logic [7:0]       w_up;
    logic [3:0]       w_n;
    logic [32:0]      w_full;

    assign w_busy_out = r_fin || (r_ovalid && !i_ready);
    assign w_take     = !i_empty && !w_busy_out;
    assign w_bit      = i_item.data[3'd7 - r_bit];
    assign w_endbyte  = i_item.drop || (r_bit == 3'd7);
    assign o_pop      = w_take && w_endbyte;
    assign o_valid    = r_ovalid;
    assign o_res      = r_res;
    assign w_n        = stage_bits(r_stage);

    always_comb begin
        n_stage  = r_stage;
        n_lz     = r_lz;
        n_code   = r_code;
        n_left   = r_left;
        n_lidx   = r_lidx;
        n_lent   = r_lent;
        n_prev   = r_prev;
        n_refrem = r_refrem;
        n_sz     = r_sz;
        n_hf     = r_hf;
        n_err    = r_err;
        w_done   = 1'b0;
        w_v      = '0;
        w_delta  = '0;
        w_up     = '0;
        w_full   = '0;
        if (w_take && !i_item.drop && !r_err && r_stage != ST_DONE) begin
            if (w_n == 4'd0) begin
                if (r_left == '0) begin
                    if (!w_bit) begin
                        n_lz = r_lz + 1'b1;
                        if (n_lz >= LZW'(CODE_WIDTH)) begin
                            n_err = 1'b1;
                        end
                    end else if (r_lz == '0) begin
                        w_done = 1'b1;
                    end else begin
                        n_left = r_lz;
                        n_code = '0;
                    end
                end else begin
                    n_code = {r_code[CODE_WIDTH-2:0], w_bit};
                    n_left = r_left - 1'b1;
                    if (n_left == '0) begin
                        w_full = (33'd1 << r_lz) - 33'd1 + 33'(n_code);
                        w_v    = w_full[31:0];
                        w_done = 1'b1;
                        n_lz   = '0;
                        n_code = '0;
                    end
                end
            end else begin
                n_code = {r_code[CODE_WIDTH-2:0], w_bit};
                n_left = r_left + 1'b1;
                if (n_left >= LZW'(w_n)) begin
                    w_v    = 32'(n_code[7:0]);
                    w_done = 1'b1;
                    n_code = '0;
                    n_left = '0;
                end
            end
            if (w_done && !n_err) begin
                case (r_stage)
                    ST_HDR: begin
                        if (w_v[4:0] != 5'd7) n_err = 1'b1;
                        else n_stage = ST_PROFILE;
                    end
                    ST_PROFILE: begin n_hf[0] = w_v[7:0]; n_stage = ST_CONSTR; end
                    ST_CONSTR:  n_stage = ST_LEVEL;
                    ST_LEVEL:   begin n_hf[1] = w_v[7:0]; n_stage = ST_SPSID; end
                    ST_SPSID: begin
                        if (high_profile(r_hf[0])) begin
                            n_stage = ST_CHROMA;
                        end else begin
                            n_hf[2] = 8'd1; n_hf[3] = 8'd8; n_hf[4] = 8'd8;
                            n_stage = ST_LOG2FN;
                        end
                    end
                    ST_CHROMA: begin
                        n_hf[2] = (w_v > 32'd255) ? 8'd255 : w_v[7:0];
                        n_stage = (w_v == 32'd3) ? ST_SEP : ST_LDEPTH;
                    end
                    ST_SEP: n_stage = ST_LDEPTH;
                    ST_LDEPTH: begin
                        n_hf[3] = (w_v > 32'd247) ? 8'd255 : w_v[7:0] + 8'd8;
                        n_stage = ST_CDEPTH;
                    end
                    ST_CDEPTH: begin
                        n_hf[4] = (w_v > 32'd247) ? 8'd255 : w_v[7:0] + 8'd8;
                        n_stage = ST_BYPASS;
                    end
                    ST_BYPASS: n_stage = ST_SMFLAG;
                    ST_SMFLAG: begin
                        n_lidx  = '0;
                        n_stage = w_v[0] ? ST_LFLAG : ST_LOG2FN;
                    end
                    ST_LFLAG: begin
                        if (w_v[0]) begin
                            n_lent  = '0;
                            n_prev  = 8'd8;
                            n_stage = ST_LDELTA;
                        end else begin
                            n_lidx  = r_lidx + 1'b1;
                            n_stage = (n_lidx >= ((r_hf[2] == 8'd3) ? 4'd12 : 4'd8))
                                      ? ST_LOG2FN : ST_LFLAG;
                        end
                    end
                    ST_LDELTA: begin
                        // se(v) mapped to mod-256 delta
                        w_delta = w_v[0] ? ({1'b0, w_v[31:1]} + 32'd1)
                                         : (32'd0 - {1'b0, w_v[31:1]});
                        w_up   = r_prev + w_delta[7:0];
                        if (w_up != 8'd0) n_prev = w_up;
                        n_lent = r_lent + 1'b1;
                        if (w_up == 8'd0 ||
                            n_lent >= ((r_lidx < 4'd6) ? 7'd16 : 7'd64)) begin
                            n_lidx  = r_lidx + 1'b1;
                            n_stage = (n_lidx >= ((r_hf[2] == 8'd3) ? 4'd12 : 4'd8))
                                      ? ST_LOG2FN : ST_LFLAG;
                        end
                    end
                    ST_LOG2FN: n_stage = ST_POCTYPE;
                    ST_POCTYPE: n_stage = (w_v == 32'd0) ? ST_LOG2POC :
                                          (w_v == 32'd1) ? ST_DPOAZ : ST_MAXREF;
                    ST_LOG2POC: n_stage = ST_MAXREF;
                    ST_DPOAZ:   n_stage = ST_OFFNR;
                    ST_OFFNR:   n_stage = ST_OFFTB;
                    ST_OFFTB:   n_stage = ST_NREF;
                    ST_NREF: begin
                        n_refrem = w_v;
                        n_stage  = (w_v == 32'd0) ? ST_MAXREF : ST_OFFREF;
                    end
                    ST_OFFREF: begin
                        n_refrem = r_refrem - 32'd1;
                        if (n_refrem == 32'd0) n_stage = ST_MAXREF;
                    end
                    ST_MAXREF: n_stage = ST_GAPS;
                    ST_GAPS:   n_stage = ST_WIDTH;
                    ST_WIDTH:  begin n_sz[0] = w_v; n_stage = ST_HEIGHT; end
                    ST_HEIGHT: begin n_sz[1] = w_v; n_stage = ST_FMO; end
                    ST_FMO: begin
                        n_hf[5] = {7'd0, w_v[0]};
                        n_stage = w_v[0] ? ST_D8 : ST_MBAFF;
                    end
                    ST_MBAFF: n_stage = ST_D8;
                    ST_D8:    n_stage = ST_CROPF;
                    ST_CROPF: n_stage = w_v[0] ? ST_CL : ST_DONE;
                    ST_CL: begin n_sz[2] = w_v; n_stage = ST_CR; end
                    ST_CR: begin n_sz[3] = w_v; n_stage = ST_CT; end
                    ST_CT: begin n_sz[4] = w_v; n_stage = ST_CB; end
                    ST_CB: begin n_sz[5] = w_v; n_stage = ST_DONE; end
                    default: n_stage = ST_DONE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_take && w_endbyte && i_item.last)) begin
            r_stage  <= ST_HDR;
            r_bit    <= '0;
            r_lz     <= '0;
            r_code   <= '0;
            r_left   <= '0;
            r_lidx   <= '0;
            r_lent   <= '0;
            r_prev   <= 8'd8;
            r_refrem <= '0;
            r_err    <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_sz[i] <= '0;
                r_hf[i] <= '0;
            end
        end else begin
            if (w_take) begin
                r_bit <= w_endbyte ? 3'd0 : r_bit + 3'd1;
            end
            r_stage  <= n_stage;
            r_lz     <= n_lz;
            r_code   <= n_code;
            r_left   <= n_left;
            r_lidx   <= n_lidx;
            r_lent   <= n_lent;
            r_prev   <= n_prev;
            r_refrem <= n_refrem;
            r_err    <= n_err;
            r_sz     <= n_sz;
            r_hf     <= n_hf;
        end
    end

    // first stage after the last byte: size terms; second: clamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_fin <= w_take && w_endbyte && i_item.last;
            if (r_fin) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_endbyte && i_item.last) begin
            r_fin_ok <= !n_err && (n_stage == ST_DONE);
            r_res.profile      <= n_hf[0];
            r_res.level        <= n_hf[1];
            r_res.chroma_format <= (n_hf[2] > 8'd3) ? 2'd3 : n_hf[2][1:0];
            r_res.luma_depth   <= n_hf[3];
            r_res.chroma_depth <= n_hf[4];
            r_res.frame_only   <= n_hf[5][0];
            r_wpos <= ({4'd0, n_sz[0]} + 36'd1) << 4;
            r_wneg <= ({4'd0, n_sz[2]} + {4'd0, n_sz[3]}) << 1;
            r_hpos <= ({4'd0, n_sz[1]} + 36'd1) << 4;
            r_hneg <= n_hf[5][0] ? (({4'd0, n_sz[4]} + {4'd0, n_sz[5]}) << 1)
                                 : (({4'd0, n_sz[4]} + {4'd0, n_sz[5]}) << 2);
        end
        if (r_fin) begin
            r_res.valid_res <= r_fin_ok;
            if (!r_fin_ok) begin
                r_res.profile <= '0; r_res.level <= '0; r_res.chroma_format <= '0;
                r_res.luma_depth <= '0; r_res.chroma_depth <= '0;
                r_res.frame_only <= 1'b0;
                r_res.pic_width <= '0; r_res.pic_height <= '0;
            end else begin
                r_res.pic_width  <= (r_wneg >= r_wpos) ? 16'd0 :
                    ((r_wpos - r_wneg) > 36'd65535) ? 16'hffff : 16'(r_wpos - r_wneg);
                r_res.pic_height <= (r_hneg >= r_hpos) ? 16'd0 :
                    ((r_hpos - r_hneg) > 36'd65535) ? 16'hffff : 16'(r_hpos - r_hneg);
            end
        end
    end
endmodule

FILE: src/h264_sps_header_parser.sv
// ---------------------------------------------------------------------------
// h264_sps_header_parser
// H.264 SPS parser: raw NAL bytes in, one decoded header result per unit.
// ---------------------------------------------------------------------------
// Input stream: one byte of the SPS NAL unit per transaction, header byte
// first, no start code; s_axis_tlast marks the final byte. Emulation 0x03
// bytes after two zeros are flagged by the front end, skipped by the engine.
// A four-entry queue sits between the front end and the bit engine.
// The bit engine consumes one bit per cycle while a byte is queued and the
// output is not stalled. A dropped emulation byte is taken whole, and the
// engine pauses while the result is formed; its single-bit loop sets the rate.
// Output stream: one registered transaction per unit, after the engine has
// taken the last byte. valid_res is 0 (all other fields 0) on a wrong NAL
// type, truncation or an over-long Exp-Golomb code.
// If the receiver stalls, the result is held and the engine pauses; bytes
// keep entering the queue until it fills.
// Reset (synchronous, active low) clears the queue and all parse state.
// ---------------------------------------------------------------------------
module h264_sps_header_parser
    import sps_pkg::*;
#(
    parameter int CODE_WIDTH = CodeWidthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // sps_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // valid_res, profile, level, chroma_format, luma_depth, chroma_depth,
    // pic_width, pic_height, frame_only (from bit 0 up), 4 pad bits
    output logic [71:0] m_axis_tdata
);
    logic       w_push, w_full, w_pop, w_empty;
    t_byte_item w_in_item, w_q_item;
    t_result    w_res;

    sps_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .i_data(s_axis_tdata), .i_last(s_axis_tlast),
        .o_ready(s_axis_tready), .o_push(w_push), .o_item(w_in_item),
        .i_full(w_full)
    );

    sps_fifo #(.DEPTH(FifoDepth)) u_fifo (
        .i_clk, .i_rst_n,
        .i_push(w_push), .i_item(w_in_item), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_item(w_q_item)
    );

    sps_engine #(.CODE_WIDTH(CODE_WIDTH)) u_engine (
        .i_clk, .i_rst_n,
        .i_empty(w_empty), .i_item(w_q_item), .o_pop(w_pop),
        .o_valid(m_axis_tvalid), .o_res(w_res), .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = {4'd0, w_res.frame_only, w_res.pic_height, w_res.pic_width,
                           w_res.chroma_depth, w_res.luma_depth, w_res.chroma_format,
                           w_res.level, w_res.profile, w_res.valid_res};
endmodule
